@@ hw/rtl/dcq_pkg.sv @@
`default_nettype none

package dcq_pkg;

  // default ring size and fixed field widths
  localparam int DCQ_DEPTH = 1024;
  localparam int CAP_W     = 11;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // command codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_STATUS     = 3'd4
  } dcq_op_t;

endpackage

`default_nettype wire

@@ hw/rtl/bounded_circular_deque.sv @@
`default_nettype none

// Bounded double-ended queue of 32-bit signed words in a ring RAM of DEPTH
// entries. A command (push front, push rear, pop front, pop rear, status) is
// taken at any clock edge with start high; busy is always low, so one command
// per cycle is sustained. Each command gives exactly one result, strobed by
// out_valid for one cycle, in the cycle after acceptance; the result cannot be
// stalled and must be captured in that cycle. The result is registered: the
// registered read ports of the ring RAM fetch the new front and rear words. A
// capacity write (cfg_valid, always ready) must only happen while no result is
// pending; capacities above DEPTH act as DEPTH, zero refuses every push. The
// RAM needs no clearing pass after reset.
module bounded_circular_deque
  import dcq_pkg::*;
#(
  parameter int DEPTH = DCQ_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          in_opcode,
  input  wire logic signed [DATA_W-1:0] in_value,
  // result channel
  output logic                          out_valid,
  output logic                          out_ok,
  output logic signed [DATA_W-1:0]      out_front_value,
  output logic signed [DATA_W-1:0]      out_rear_value,
  output logic                          out_is_empty,
  output logic                          out_is_full,
  // capacity register
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CAP_W-1:0]         cfg_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [AW-1:0]   LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [AW:0]     DEPTH_SUM = (AW + 1)'(DEPTH);
  localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(DEPTH);

  // state
  logic [CAP_W-1:0]  capacity_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  // result side
  logic              out_valid_r;
  logic              ok_r, ok_nxt;
  logic              empty_r, full_r;
  logic              byp_front_r, byp_rear_r;
  logic [DATA_W-1:0] wdata_r;

  // ring access
  logic              accept;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     front_addr, rear_addr;
  logic [DATA_W-1:0] rd_front, rd_rear;

  logic [CMPW-1:0]   cap_ext, eff_cap, count_ext, count_nxt_ext;
  logic              has_room, non_empty;
  logic [AW-1:0]     head_inc, head_dec, rear_push_addr;
  logic [AW:0]       rear_sum, push_sum;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  // effective capacity and room check
  always_comb begin
    cap_ext   = CMPW'(capacity_r);
    eff_cap   = (cap_ext > DEPTH_CMP) ? DEPTH_CMP : cap_ext;
    count_ext = CMPW'(count_r);
    has_room  = count_ext < eff_cap;
    non_empty = count_r != '0;
  end

  // neighbor ring positions
  always_comb begin
    head_inc       = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    head_dec       = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
    push_sum       = (AW + 1)'(head_r) + (AW + 1)'(count_r);
    rear_push_addr = (push_sum >= DEPTH_SUM) ? AW'(push_sum - DEPTH_SUM) : AW'(push_sum);
  end

  // command decode and next state
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    we        = 1'b0;
    waddr     = rear_push_addr;
    unique case (dcq_op_t'(in_opcode))
      OP_PUSH_FRONT: begin
        if (has_room) begin
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
          ok_nxt    = 1'b1;
          we        = accept;
          waddr     = head_dec;
        end
      end
      OP_PUSH_REAR: begin
        if (has_room) begin
          count_nxt = count_r + 1'b1;
          ok_nxt    = 1'b1;
          we        = accept;
        end
      end
      OP_POP_FRONT: begin
        if (non_empty) begin
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (non_empty) begin
          count_nxt = count_r - 1'b1;
          ok_nxt    = 1'b1;
        end
      end
      OP_STATUS: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // front and rear addresses after the command
  always_comb begin
    count_nxt_ext = CMPW'(count_nxt);
    front_addr    = head_nxt;
    rear_sum      = (AW + 1)'(head_nxt) + (AW + 1)'(AW'(count_nxt - 1'b1));
    rear_addr     = (rear_sum >= DEPTH_SUM) ? AW'(rear_sum - DEPTH_SUM) : AW'(rear_sum);
  end

  // pointer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  // result flags and write bypass
  always_ff @(posedge clk) begin
    ok_r        <= ok_nxt;
    empty_r     <= count_nxt == '0;
    full_r      <= count_nxt_ext >= eff_cap;
    byp_front_r <= we && (waddr == front_addr);
    byp_rear_r  <= we && (waddr == rear_addr);
    wdata_r     <= in_value;
  end

  dcq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (in_value),
    .raddr_a (front_addr),
    .rdata_a (rd_front),
    .raddr_b (rear_addr),
    .rdata_b (rd_rear)
  );

  // result word
  always_comb begin
    out_valid    = out_valid_r;
    out_ok       = ok_r;
    out_is_empty = empty_r;
    out_is_full  = full_r;
    if (empty_r) begin
      out_front_value = '1;
      out_rear_value  = '1;
    end else begin
      out_front_value = byp_front_r ? wdata_r : rd_front;
      out_rear_value  = byp_rear_r ? wdata_r : rd_rear;
    end
  end

  // count never passes the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(count_r) <= CW'(DEPTH))
    else $error("entry count above ring size");

  // each accepted command gives a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result missing after accepted command");

  // no result without a command
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without command");

  // a successful push grows the count by one
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && we) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not grow count");

  // refused commands leave the pointers alone
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !ok_nxt) |=> ($stable(count_r) && $stable(head_r)))
    else $error("refused command moved pointers");

endmodule

`default_nettype wire

@@ hw/rtl/dcq_ram.sv @@
`default_nettype none

module dcq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two registered read ports, old data on collision
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire
